// File: sv/scfp_pkg.sv
// Shared types and constants for the switched-cap filter programmer.
package scfp_pkg;

    localparam int F_WORD_MAX = 63;

    // K base constants in Q26
    localparam logic [26:0] HALF_PI_Q26 = 27'd105414357;
    localparam logic [63:0] SQRT2_Q26 = 64'd94906266;
    localparam logic [63:0] HALF_PI_M2_W = (64'd105414357 << 26) / SQRT2_Q26;
    localparam logic [26:0] HALF_PI_M2_Q26 = HALF_PI_M2_W[26:0];

    localparam logic [26:0] F0_CAP = 27'h7FFFFFF;
    localparam logic [22:0] CLOCK_SAT = 23'h7FFFFF;

    localparam logic [22:0] MAX_CLOCK_RST = 23'd4000000;
    localparam logic [15:0] Q_MIN_RST = 16'd128;

    // register index (paddr[2])
    localparam logic REG_MAX_CLOCK = 1'b0;
    localparam logic REG_Q_MIN = 1'b1;

    // request kinds
    localparam logic [1:0] KIND_CENTER = 2'd0;
    localparam logic [1:0] KIND_LOWPASS = 2'd1;
    localparam logic [1:0] KIND_HIGHPASS = 2'd2;
    localparam logic [1:0] KIND_EDGES = 2'd3;

    // mode codes
    localparam logic [1:0] MODE_SQRT2 = 2'd1;
    localparam logic [1:0] MODE_HIGHPASS = 2'd2;

    localparam logic [13:0] QW_NUM_M2 = 14'd9051;
    localparam logic [6:0] QN_MAX = 7'd127;

    localparam int DS_CNT_W = 7;

    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] freq_a;
        logic [23:0] freq_b;
        logic [15:0] q_value;
        logic [1:0]  work_mode;
        logic        channel;
    } item_t;

    typedef struct packed {
        logic [3:0]  write_addr;
        logic [1:0]  write_data;
        logic [22:0] clock_hz;
        logic        last;
    } result_t;

    typedef enum logic {
        DS_DIV,
        DS_SQRT
    } ds_op_t;

    typedef struct packed {
        logic                start;
        ds_op_t              op;
        logic [63:0]         num;
        logic [33:0]         den;
        logic [DS_CNT_W-1:0] cnt;
    } ds_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } ds_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_QQ,
        ST_D_START,
        ST_D_WAIT,
        ST_XX,
        ST_S_START,
        ST_S_WAIT,
        ST_R2_START,
        ST_R2_WAIT,
        ST_RT_START,
        ST_RT_WAIT,
        ST_F1_START,
        ST_F1_WAIT,
        ST_F2_MUL,
        ST_F2_GET,
        ST_K3_MUL,
        ST_K3_SQ_START,
        ST_K3_SQ_WAIT,
        ST_K3_DIV_START,
        ST_K3_DIV_WAIT,
        ST_QW,
        ST_QW_MUL,
        ST_QW_START,
        ST_QW_WAIT,
        ST_P_MUL,
        ST_P_GET,
        ST_FS,
        ST_OUT
    } state_t;

endpackage

// File: sv/scfp_divsqrt.sv
// Shared bit-serial divider and integer square root unit.
module scfp_divsqrt (
    input  logic              clk,
    input  logic              rst_n,
    input  scfp_pkg::ds_req_t req,
    output scfp_pkg::ds_rsp_t rsp
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    scfp_pkg::ds_op_t              op_reg, op_next;
    logic [scfp_pkg::DS_CNT_W-1:0] cnt_reg, cnt_next;
    logic [63:0]                   a_reg, a_next;
    logic [63:0]                   b_reg, b_next;
    logic [34:0]                   rem_reg, rem_next;
    logic [33:0]                   den_reg, den_next;

    logic [34:0] rem_sh;
    logic        div_ge;
    logic [4:0]  sq_idx;
    logic [63:0] sq_bit;
    logic [63:0] sq_try;
    logic        sq_ge;

    always_comb
    begin
        rem_sh = {rem_reg[33:0], a_reg[63]};
        div_ge = rem_sh >= {1'b0, den_reg};
        sq_idx = cnt_reg[4:0] - 5'd1;
        sq_bit = 64'd1 << {sq_idx, 1'b0};
        sq_try = b_reg + sq_bit;
        sq_ge = a_reg >= sq_try;

        busy_next = busy_reg;
        done_next = 1'b0;
        op_next = op_reg;
        cnt_next = cnt_reg;
        a_next = a_reg;
        b_next = b_reg;
        rem_next = rem_reg;
        den_next = den_reg;

        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            op_next = req.op;
            cnt_next = req.cnt;
            a_next = req.num;
            b_next = '0;
            rem_next = '0;
            den_next = req.den;
        end
        else if (busy_reg)
        begin
            case (op_reg)
                scfp_pkg::DS_DIV:
                begin
                    // restoring divide: quotient bits shift in as dividend shifts out
                    rem_next = div_ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
                    a_next = {a_reg[62:0], div_ge};
                end
                scfp_pkg::DS_SQRT:
                begin
                    if (sq_ge)
                    begin
                        a_next = a_reg - sq_try;
                        b_next = (b_reg >> 1) + sq_bit;
                    end
                    else
                    begin
                        b_next = b_reg >> 1;
                    end
                end
                default:
                begin
                    a_next = a_reg;
                end
            endcase
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == scfp_pkg::DS_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        a_reg <= a_next;
        b_reg <= b_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res = (op_reg == scfp_pkg::DS_SQRT) ? b_reg : a_reg;

endmodule

// File: sv/switched_cap_filter_programmer_core.sv
// Top level: request sequencer, shared multiplier, F search and register port.
// Divides and square roots run in the shared divide/sqrt unit, one bit per cycle. Eight
// result beats follow back to back and busy stays high to the last. Results cannot be stalled.
// Reset (rst_n low, async) returns to idle and loads max_clock_hz = 4000000, q_min = 128.
module switched_cap_filter_programmer_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              start,
    input  scfp_pkg::item_t   item,
    output logic              busy,
    output logic              strobe,
    output scfp_pkg::result_t result
);

    localparam logic [22:0] QN_MAX_SH = {scfp_pkg::QN_MAX, 16'b0};

    scfp_pkg::state_t  state_reg, state_next;
    scfp_pkg::item_t   in_reg, in_next;
    logic [1:0]        mode_reg, mode_next;
    logic [15:0]       q_reg, q_next;
    logic [15:0]       qe_reg, qe_next;
    logic              neg_reg, neg_next;
    logic [31:0]       ax_reg, ax_next;
    logic [32:0]       sum_reg, sum_next;
    logic [31:0]       r2_reg, r2_next;
    logic [31:0]       ratio_reg, ratio_next;
    logic [36:0]       f0_reg, f0_next;
    logic [6:0]        qn_reg, qn_next;
    logic [53:0]       p_reg, p_next;
    logic [61:0]       acc_reg, acc_next;
    logic [61:0]       best_reg, best_next;
    logic [5:0]        f_reg, f_next;
    logic [5:0]        fword_reg, fword_next;
    logic [2:0]        k_reg, k_next;
    logic [63:0]       mul_reg;
    logic [22:0]       max_clock_reg;
    logic [15:0]       q_min_reg;

    logic [31:0]       mul_a, mul_b;
    scfp_pkg::ds_req_t ds_req;
    scfp_pkg::ds_rsp_t ds_rsp;

    logic [31:0] d_val;
    logic [32:0] s_sum;
    logic [15:0] q_one;
    logic [15:0] q_eff;
    logic [23:0] v_raw, v_clamp, v_round;
    logic [26:0] fc;
    logic [26:0] k_base;
    logic [61:0] p_ext;
    logic [56:0] limit;
    logic [27:0] clk_full;
    logic [22:0] clk_sat;
    logic [1:0]  data_sel;
    logic        accept;

    assign accept = start && (state_reg == scfp_pkg::ST_IDLE);

    scfp_divsqrt u_ds (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ds_req),
        .rsp   (ds_rsp)
    );

    always_comb
    begin
        d_val = ds_rsp.res[31:0];
        s_sum = {1'b0, ax_reg} + {1'b0, ds_rsp.res[31:0]};
        q_one = (in_reg.q_value == 16'd0) ? 16'd1 : in_reg.q_value;
        q_eff = (q_reg < q_min_reg) ? q_min_reg : q_reg;
        v_raw = 24'h800000 - {1'b0, ds_rsp.res[22:0]};
        if (|ds_rsp.res[63:23])
        begin
            v_raw = '0;
        end
        v_clamp = (v_raw > {1'b0, QN_MAX_SH}) ? {1'b0, QN_MAX_SH} : v_raw;
        v_round = v_clamp + 24'h008000;
        fc = (f0_reg > {10'b0, scfp_pkg::F0_CAP}) ? scfp_pkg::F0_CAP : f0_reg[26:0];
        k_base = (mode_reg == scfp_pkg::MODE_SQRT2) ? scfp_pkg::HALF_PI_M2_Q26
                                                     : scfp_pkg::HALF_PI_Q26;
        p_ext = {8'b0, mul_reg[53:0]};
        limit = {max_clock_reg, 34'b0};
        clk_full = best_reg[61:34];
        clk_sat = (clk_full > {5'b0, scfp_pkg::CLOCK_SAT}) ? scfp_pkg::CLOCK_SAT
                                                           : clk_full[22:0];
    end

    always_comb
    begin
        state_next = state_reg;
        in_next = in_reg;
        mode_next = mode_reg;
        q_next = q_reg;
        qe_next = qe_reg;
        neg_next = neg_reg;
        ax_next = ax_reg;
        sum_next = sum_reg;
        r2_next = r2_reg;
        ratio_next = ratio_reg;
        f0_next = f0_reg;
        qn_next = qn_reg;
        p_next = p_reg;
        acc_next = acc_reg;
        best_next = best_reg;
        f_next = f_reg;
        fword_next = fword_reg;
        k_next = k_reg;
        mul_a = '0;
        mul_b = '0;
        ds_req.start = 1'b0;
        ds_req.op = scfp_pkg::DS_DIV;
        ds_req.num = '0;
        ds_req.den = '0;
        ds_req.cnt = '0;

        case (state_reg)
            scfp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    in_next = item;
                    q_next = item.q_value;
                    mode_next = (item.kind == scfp_pkg::KIND_HIGHPASS) ?
                                scfp_pkg::MODE_HIGHPASS : item.work_mode;
                    case (item.kind)
                        scfp_pkg::KIND_CENTER:
                        begin
                            f0_next = {9'b0, item.freq_a, 4'b0};
                            state_next = scfp_pkg::ST_QW;
                        end
                        scfp_pkg::KIND_EDGES:
                            state_next = scfp_pkg::ST_K3_MUL;
                        default:
                            state_next = scfp_pkg::ST_QQ;
                    endcase
                end
            end
            scfp_pkg::ST_QQ:
            begin
                mul_a = {16'b0, q_one};
                mul_b = {16'b0, q_one};
                state_next = scfp_pkg::ST_D_START;
            end
            scfp_pkg::ST_D_START:
            begin
                // 2^31 / q^2, 32 quotient bits
                ds_req.start = 1'b1;
                ds_req.num = 64'h8000_0000_0000_0000;
                ds_req.den = {2'b0, mul_reg[31:0]};
                ds_req.cnt = scfp_pkg::DS_CNT_W'(32);
                state_next = scfp_pkg::ST_D_WAIT;
            end
            scfp_pkg::ST_D_WAIT:
            begin
                if (ds_rsp.done)
                begin
                    neg_next = d_val > 32'd65536;
                    ax_next = (d_val > 32'd65536) ? (d_val - 32'd65536)
                                                   : (32'd65536 - d_val);
                    state_next = scfp_pkg::ST_XX;
                end
            end
            scfp_pkg::ST_XX:
            begin
                mul_a = ax_reg;
                mul_b = ax_reg;
                state_next = scfp_pkg::ST_S_START;
            end
            scfp_pkg::ST_S_START:
            begin
                ds_req.start = 1'b1;
                ds_req.op = scfp_pkg::DS_SQRT;
                ds_req.num = mul_reg + 64'h1_0000_0000;
                ds_req.cnt = scfp_pkg::DS_CNT_W'(32);
                state_next = scfp_pkg::ST_S_WAIT;
            end
            scfp_pkg::ST_S_WAIT:
            begin
                if (ds_rsp.done)
                begin
                    sum_next = s_sum;
                    if (neg_reg)
                    begin
                        state_next = scfp_pkg::ST_R2_START;
                    end
                    else
                    begin
                        r2_next = {s_sum[17:0], 14'b0};
                        state_next = scfp_pkg::ST_RT_START;
                    end
                end
            end
            scfp_pkg::ST_R2_START:
            begin
                // 2^46 / (s + |x|), 47 quotient bits
                ds_req.start = 1'b1;
                ds_req.num = 64'h8000_0000_0000_0000;
                ds_req.den = {1'b0, sum_reg};
                ds_req.cnt = scfp_pkg::DS_CNT_W'(47);
                state_next = scfp_pkg::ST_R2_WAIT;
            end
            scfp_pkg::ST_R2_WAIT:
            begin
                if (ds_rsp.done)
                begin
                    r2_next = ds_rsp.res[31:0];
                    state_next = scfp_pkg::ST_RT_START;
                end
            end
            scfp_pkg::ST_RT_START:
            begin
                ds_req.start = 1'b1;
                ds_req.op = scfp_pkg::DS_SQRT;
                ds_req.num = {2'b0, r2_reg, 30'b0};
                ds_req.cnt = scfp_pkg::DS_CNT_W'(32);
                state_next = scfp_pkg::ST_RT_WAIT;
            end
            scfp_pkg::ST_RT_WAIT:
            begin
                if (ds_rsp.done)
                begin
                    ratio_next = ds_rsp.res[31:0];
                    state_next = (in_reg.kind == scfp_pkg::KIND_LOWPASS) ?
                                 scfp_pkg::ST_F1_START : scfp_pkg::ST_F2_MUL;
                end
            end
            scfp_pkg::ST_F1_START:
            begin
                // (fa << 34) / ratio, 58 quotient bits
                ds_req.start = 1'b1;
                ds_req.num = {in_reg.freq_a, 40'b0};
                ds_req.den = {2'b0, ratio_reg};
                ds_req.cnt = scfp_pkg::DS_CNT_W'(58);
                state_next = scfp_pkg::ST_F1_WAIT;
            end
            scfp_pkg::ST_F1_WAIT:
            begin
                if (ds_rsp.done)
                begin
                    f0_next = ds_rsp.res[36:0];
                    state_next = scfp_pkg::ST_QW;
                end
            end
            scfp_pkg::ST_F2_MUL:
            begin
                mul_a = {8'b0, in_reg.freq_a};
                mul_b = ratio_reg;
                state_next = scfp_pkg::ST_F2_GET;
            end
            scfp_pkg::ST_F2_GET:
            begin
                f0_next = mul_reg[62:26];
                state_next = scfp_pkg::ST_QW;
            end
            scfp_pkg::ST_K3_MUL:
            begin
                mul_a = {8'b0, in_reg.freq_a};
                mul_b = {8'b0, in_reg.freq_b};
                state_next = scfp_pkg::ST_K3_SQ_START;
            end
            scfp_pkg::ST_K3_SQ_START:
            begin
                ds_req.start = 1'b1;
                ds_req.op = scfp_pkg::DS_SQRT;
                ds_req.num = {mul_reg[55:0], 8'b0};
                ds_req.cnt = scfp_pkg::DS_CNT_W'(32);
                state_next = scfp_pkg::ST_K3_SQ_WAIT;
            end
            scfp_pkg::ST_K3_SQ_WAIT:
            begin
                if (ds_rsp.done)
                begin
                    f0_next = ds_rsp.res[36:0];
                    if (in_reg.freq_b == in_reg.freq_a)
                    begin
                        // infinite Q
                        qn_next = scfp_pkg::QN_MAX;
                        state_next = scfp_pkg::ST_P_MUL;
                    end
                    else if (in_reg.freq_b < in_reg.freq_a)
                    begin
                        q_next = '0;
                        state_next = scfp_pkg::ST_QW;
                    end
                    else
                    begin
                        state_next = scfp_pkg::ST_K3_DIV_START;
                    end
                end
            end
            scfp_pkg::ST_K3_DIV_START:
            begin
                // f0*16 / (fb - fa), 33 quotient bits
                ds_req.start = 1'b1;
                ds_req.num = {f0_reg[28:0], 35'b0};
                ds_req.den = {10'b0, in_reg.freq_b - in_reg.freq_a};
                ds_req.cnt = scfp_pkg::DS_CNT_W'(33);
                state_next = scfp_pkg::ST_K3_DIV_WAIT;
            end
            scfp_pkg::ST_K3_DIV_WAIT:
            begin
                if (ds_rsp.done)
                begin
                    q_next = (|ds_rsp.res[63:16]) ? 16'hFFFF : ds_rsp.res[15:0];
                    state_next = scfp_pkg::ST_QW;
                end
            end
            scfp_pkg::ST_QW:
            begin
                qe_next = q_eff;
                if (q_eff == 16'd0)
                begin
                    qn_next = '0;
                    state_next = scfp_pkg::ST_P_MUL;
                end
                else
                begin
                    state_next = scfp_pkg::ST_QW_MUL;
                end
            end
            scfp_pkg::ST_QW_MUL:
            begin
                mul_a = 32'd100;
                mul_b = {16'b0, qe_reg};
                state_next = scfp_pkg::ST_QW_START;
            end
            scfp_pkg::ST_QW_START:
            begin
                // t = c * 2^24 / q, 38 quotient bits
                ds_req.start = 1'b1;
                ds_req.cnt = scfp_pkg::DS_CNT_W'(38);
                if (mode_reg == scfp_pkg::MODE_SQRT2)
                begin
                    ds_req.num = {scfp_pkg::QW_NUM_M2, 50'b0};
                    ds_req.den = mul_reg[33:0];
                end
                else
                begin
                    ds_req.num = 64'h0100_0000_0000_0000;
                    ds_req.den = {18'b0, qe_reg};
                end
                state_next = scfp_pkg::ST_QW_WAIT;
            end
            scfp_pkg::ST_QW_WAIT:
            begin
                if (ds_rsp.done)
                begin
                    qn_next = v_round[22:16];
                    state_next = scfp_pkg::ST_P_MUL;
                end
            end
            scfp_pkg::ST_P_MUL:
            begin
                mul_a = {5'b0, k_base};
                mul_b = {5'b0, fc};
                state_next = scfp_pkg::ST_P_GET;
            end
            scfp_pkg::ST_P_GET:
            begin
                // K(0)*fc = 26 * base * fc
                p_next = mul_reg[53:0];
                acc_next = (p_ext << 4) + (p_ext << 3) + (p_ext << 1);
                best_next = (p_ext << 4) + (p_ext << 3) + (p_ext << 1);
                f_next = '0;
                fword_next = '0;
                state_next = scfp_pkg::ST_FS;
            end
            scfp_pkg::ST_FS:
            begin
                if (acc_reg <= {5'b0, limit})
                begin
                    fword_next = f_reg;
                    best_next = acc_reg;
                    if (f_reg == 6'(scfp_pkg::F_WORD_MAX))
                    begin
                        k_next = '0;
                        state_next = scfp_pkg::ST_OUT;
                    end
                    else
                    begin
                        acc_next = acc_reg + {8'b0, p_reg};
                        f_next = f_reg + 6'd1;
                    end
                end
                else
                begin
                    k_next = '0;
                    state_next = scfp_pkg::ST_OUT;
                end
            end
            scfp_pkg::ST_OUT:
            begin
                k_next = k_reg + 3'd1;
                if (k_reg == 3'd7)
                begin
                    state_next = scfp_pkg::ST_IDLE;
                end
            end
            default:
                state_next = scfp_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        case (k_reg)
            3'd0: data_sel = mode_reg;
            3'd1: data_sel = fword_reg[1:0];
            3'd2: data_sel = fword_reg[3:2];
            3'd3: data_sel = fword_reg[5:4];
            3'd4: data_sel = qn_reg[1:0];
            3'd5: data_sel = qn_reg[3:2];
            3'd6: data_sel = qn_reg[5:4];
            default: data_sel = {1'b0, qn_reg[6]};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scfp_pkg::ST_IDLE;
            k_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg <= in_next;
        mode_reg <= mode_next;
        q_reg <= q_next;
        qe_reg <= qe_next;
        neg_reg <= neg_next;
        ax_reg <= ax_next;
        sum_reg <= sum_next;
        r2_reg <= r2_next;
        ratio_reg <= ratio_next;
        f0_reg <= f0_next;
        qn_reg <= qn_next;
        p_reg <= p_next;
        acc_reg <= acc_next;
        best_reg <= best_next;
        f_reg <= f_next;
        fword_reg <= fword_next;
        mul_reg <= mul_a * mul_b;
    end

    // register port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_clock_reg <= scfp_pkg::MAX_CLOCK_RST;
            q_min_reg <= scfp_pkg::Q_MIN_RST;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == scfp_pkg::REG_MAX_CLOCK)
            begin
                max_clock_reg <= pwdata[22:0];
            end
            else
            begin
                q_min_reg <= pwdata[15:0];
            end
        end
    end

    assign prdata = (paddr[2] == scfp_pkg::REG_Q_MIN) ? {16'b0, q_min_reg}
                                                      : {9'b0, max_clock_reg};
    assign pready = 1'b1;

    assign busy = (state_reg != scfp_pkg::ST_IDLE);
    assign strobe = (state_reg == scfp_pkg::ST_OUT);
    assign result.write_addr = {in_reg.channel, k_reg};
    assign result.write_data = data_sel;
    assign result.clock_hz = clk_sat;
    assign result.last = (k_reg == 3'd7);

endmodule

// File: sv/scfp_checker.sv
// Port-level checks for the filter programmer, bound to the top level.
module scfp_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              strobe,
    input scfp_pkg::result_t result
);

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("result beat outside busy window");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.last |=> !strobe)
        else $error("beat after last");

    a_addr_step: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |=>
            strobe && result.write_addr == 4'($past(result.write_addr) + 4'd1))
        else $error("write beats not consecutive");

    a_clock_same: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |=> $stable(result.clock_hz))
        else $error("clock_hz changed within a request");

endmodule

bind switched_cap_filter_programmer_core scfp_checker u_scfp_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
);
